// ----- rtl/core/asfr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Air sensor frame receiver package
// Shared constants, status codes and result types for the frame receiver.
// ----------------------------------------------------------------------------
package asfr_pkg;

  localparam int unsigned RX_DEPTH_DEF = 64;
  localparam int unsigned FRAME_LEN    = 8;
  localparam int unsigned COUNT_OUT_W  = 6;

  localparam logic [7:0] HEADER_BYTE  = 8'h5F;
  localparam logic [7:0] PREHEAT_BYTE = 8'hFF;

  typedef enum logic [0:0] {
    ACT_BYTE = 1'b0,
    ACT_IDLE = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    ST_SHORT    = 3'd0,
    ST_HEADER   = 3'd1,
    ST_CHECKSUM = 3'd2,
    ST_PREHEAT  = 3'd3,
    ST_MEASURE  = 3'd4
  } status_t;

  typedef logic [FRAME_LEN-1:0][7:0] frame_t;

  typedef struct packed {
    status_t                status;
    logic [COUNT_OUT_W-1:0] byte_count;
    logic [15:0]            voc_raw;
    logic [15:0]            formaldehyde_raw;
    logic [15:0]            co2_raw;
  } result_t;

endpackage

// ----- rtl/core/air_sensor_frame_receiver.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Air sensor frame receiver
// Collects received bytes into a frame and reports one result per frame.
// ----------------------------------------------------------------------------
// Each input word is either a received byte or a line-idle event. Bytes are
// stored at the running count, which wraps at RX_DEPTH; only the first eight
// positions are kept. An idle event with a nonzero count checks the frame,
// produces one result word and clears the frame; an idle event with an empty
// frame produces nothing.
// A result is registered in the output register, or in the skid register
// while the output register is held; the frame check before them is
// combinational. Throughput: one input word per cycle while in_ready is high.
// The result side holds an output register and a skid register, so input
// words keep flowing while one result waits; in_ready drops only when both
// are full, and returns as soon as the receiver takes a result.
// Reset clears the frame, the count and both result slots.
// ----------------------------------------------------------------------------
module air_sensor_frame_receiver
  import asfr_pkg::*;
#(
  parameter int unsigned RX_DEPTH = RX_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_action,
  input  logic [7:0]             in_data_byte,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [2:0]             out_status,
  output logic [COUNT_OUT_W-1:0] out_byte_count,
  output logic [15:0]            out_voc_raw,
  output logic [15:0]            out_formaldehyde_raw,
  output logic [15:0]            out_co2_raw
);

  localparam int unsigned CNT_W = $clog2(RX_DEPTH);
  localparam int unsigned EXT_W = (CNT_W > COUNT_OUT_W) ? CNT_W : COUNT_OUT_W;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RX_DEPTH - 1);

  logic [CNT_W-1:0] rx_count_r, rx_count_nxt;
  frame_t           frame_r, frame_nxt;
  result_t          out_r, out_nxt, skid_r, skid_nxt;
  logic             out_vld_r, out_vld_nxt, skid_vld_r, skid_vld_nxt;

  logic             accept;
  logic             push;
  logic [EXT_W-1:0] cnt_ext;
  logic             short_frame;
  result_t          new_result;

  assign in_ready    = !skid_vld_r;
  assign accept      = in_valid && in_ready;
  assign cnt_ext     = EXT_W'(rx_count_r);
  assign short_frame = cnt_ext < EXT_W'(FRAME_LEN);
  assign push        = accept && (in_action == ACT_IDLE) && (rx_count_r != '0);

  asfr_frame_check u_check (
    .frame       (frame_r),
    .short_frame (short_frame),
    .byte_count  (cnt_ext[COUNT_OUT_W-1:0]),
    .result      (new_result)
  );

  always_comb begin
    rx_count_nxt = rx_count_r;
    frame_nxt    = frame_r;
    if (accept) begin
      if (in_action == ACT_BYTE) begin
        if (short_frame) begin
          frame_nxt[rx_count_r[2:0]] = in_data_byte;
        end
        rx_count_nxt = (rx_count_r == CNT_LAST) ? '0 : rx_count_r + 1'b1;
      end else if (rx_count_r != '0) begin
        rx_count_nxt = '0;
        frame_nxt    = '0;
      end
    end
  end

  always_comb begin
    out_nxt      = out_r;
    out_vld_nxt  = out_vld_r;
    skid_nxt     = skid_r;
    skid_vld_nxt = skid_vld_r;
    if (!out_vld_r || out_ready) begin
      if (skid_vld_r) begin
        out_nxt      = skid_r;
        out_vld_nxt  = 1'b1;
        skid_nxt     = new_result;
        skid_vld_nxt = push;
      end else begin
        out_nxt     = new_result;
        out_vld_nxt = push;
      end
    end else if (push) begin
      skid_nxt     = new_result;
      skid_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_count_r <= '0;
      frame_r    <= '0;
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      rx_count_r <= rx_count_nxt;
      frame_r    <= frame_nxt;
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid            = out_vld_r;
  assign out_status           = out_r.status;
  assign out_byte_count       = out_r.byte_count;
  assign out_voc_raw          = out_r.voc_raw;
  assign out_formaldehyde_raw = out_r.formaldehyde_raw;
  assign out_co2_raw          = out_r.co2_raw;

endmodule

// ----- rtl/core/asfr_frame_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame check
// Classifies a stored eight-byte frame and extracts the raw readings.
// ----------------------------------------------------------------------------
module asfr_frame_check
  import asfr_pkg::*;
(
  input  frame_t                 frame,
  input  logic                   short_frame,
  input  logic [COUNT_OUT_W-1:0] byte_count,
  output result_t                result
);

  logic [7:0] sum;
  status_t    status;

  always_comb begin
    sum = '0;
    for (int i = 0; i < FRAME_LEN - 1; i++) begin
      sum = sum + frame[i];
    end
  end

  always_comb begin
    if (short_frame) begin
      status = ST_SHORT;
    end else if (frame[0] != HEADER_BYTE) begin
      status = ST_HEADER;
    end else if (frame[7] != sum) begin
      status = ST_CHECKSUM;
    end else if (frame[1] == PREHEAT_BYTE && frame[2] == PREHEAT_BYTE) begin
      status = ST_PREHEAT;
    end else begin
      status = ST_MEASURE;
    end
  end

  always_comb begin
    result.status     = status;
    result.byte_count = byte_count;
    if (status == ST_MEASURE) begin
      result.voc_raw          = {frame[1], frame[2]};
      result.formaldehyde_raw = {frame[3], frame[4]};
      result.co2_raw          = {frame[5], frame[6]};
    end else begin
      result.voc_raw          = '0;
      result.formaldehyde_raw = '0;
      result.co2_raw          = '0;
    end
  end

endmodule

// ----- rtl/core/asfr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame receiver checker
// Port-level properties of the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module asfr_checker
  import asfr_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [2:0]             out_status,
  input logic [COUNT_OUT_W-1:0] out_byte_count,
  input logic [15:0]            out_voc_raw,
  input logic [15:0]            out_formaldehyde_raw,
  input logic [15:0]            out_co2_raw
);

  // A stalled result word keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_byte_count) && $stable(out_voc_raw) &&
      $stable(out_formaldehyde_raw) && $stable(out_co2_raw))
    else $error("result word changed while stalled");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_MEASURE)
    else $error("status code out of range");

  // Readings are only reported for a measurement.
  a_readings_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_MEASURE |->
      out_voc_raw == '0 && out_formaldehyde_raw == '0 && out_co2_raw == '0)
    else $error("readings nonzero outside a measurement");

  // A short frame always holds between one and seven bytes.
  a_short_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_SHORT |->
      out_byte_count != '0 && out_byte_count < COUNT_OUT_W'(FRAME_LEN))
    else $error("short frame with bad byte count");

endmodule

bind air_sensor_frame_receiver asfr_checker u_asfr_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_status           (out_status),
  .out_byte_count       (out_byte_count),
  .out_voc_raw          (out_voc_raw),
  .out_formaldehyde_raw (out_formaldehyde_raw),
  .out_co2_raw          (out_co2_raw)
);
